// ===== hw/rtl/pip_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_pkg: shared types and constants for the point-in-polygon test core
// Operation codes, sequencer states, result layout and the control/status
// bundles between the sequencer and the shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
package pip_pkg;

  localparam int OP_BITS    = 2;
  localparam int CNT_BITS   = 8;
  localparam int DIGIT_BITS = 16;
  localparam int OUT_DATA_W = 16;

  localparam logic [OP_BITS-1:0] OP_START  = 2'd0;
  localparam logic [OP_BITS-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_BITS-1:0] OP_TEST   = 2'd2;

  localparam logic [CNT_BITS-1:0] CNT_MAX = 8'hFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_LOAD,
    ST_MUL,
    ST_CHK,
    ST_FIN
  } pip_state_t;

  typedef struct packed {
    logic load;
    logic step;
  } pip_mac_ctl_t;

  typedef struct packed {
    logic last;
    logic pos;
  } pip_mac_sts_t;

endpackage

// ===== hw/rtl/pip_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pip_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/pip_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_mac: shared digit-serial multiply-accumulate unit
// Forms a1*b1 - a2*b2 one 16-bit digit of b per cycle while ctl.step is high
// and reports whether the result is strictly positive.
// ----------------------------------------------------------------------------
module pip_mac
  import pip_pkg::*;
#(
  parameter int D = 33
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pip_mac_ctl_t        ctl,
  input  logic signed [D-1:0] a1,
  input  logic signed [D-1:0] b1,
  input  logic signed [D-1:0] a2,
  input  logic signed [D-1:0] b2,
  output pip_mac_sts_t        sts
);

  localparam int ND = (D + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int KW = (ND > 1) ? $clog2(ND) : 1;
  localparam int PW = DIGIT_BITS * ND;
  localparam int AW = 2 * D + 2;
  localparam int TW = D + DIGIT_BITS;

  logic [D-1:0]    mag_a_r [2];
  logic [PW-1:0]   mag_b_r [2];
  logic [1:0]      neg_r;
  logic signed [AW-1:0] acc_r;
  logic [KW-1:0]   k_r;
  logic            ph_r;

  logic [DIGIT_BITS-1:0] digit;
  logic [TW-1:0]   term;
  logic [AW-1:0]   term_sh;
  logic            sub;

  function automatic logic [D-1:0] mag(input logic signed [D-1:0] v);
    mag = v[D-1] ? (~v + D'(1)) : v;
  endfunction

  assign digit   = mag_b_r[ph_r][k_r*DIGIT_BITS +: DIGIT_BITS];
  assign term    = TW'(mag_a_r[ph_r]) * TW'(digit);
  assign term_sh = AW'(term) << {k_r, 4'b0000};
  // second product enters with the opposite sign
  assign sub     = neg_r[ph_r] ^ ph_r;

  assign sts.last = ph_r && (k_r == KW'(ND - 1));
  assign sts.pos  = !acc_r[AW-1] && (acc_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r  <= '0;
      ph_r <= 1'b0;
    end else if (ctl.load) begin
      k_r  <= '0;
      ph_r <= 1'b0;
    end else if (ctl.step) begin
      if (k_r == KW'(ND - 1)) begin
        k_r  <= '0;
        ph_r <= ~ph_r;
      end else begin
        k_r <= k_r + KW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      mag_a_r[0] <= mag(a1);
      mag_a_r[1] <= mag(a2);
      mag_b_r[0] <= PW'(mag(b1));
      mag_b_r[1] <= PW'(mag(b2));
      neg_r      <= {a2[D-1] ^ b2[D-1], a1[D-1] ^ b1[D-1]};
      acc_r      <= '0;
    end else if (ctl.step) begin
      acc_r <= sub ? (acc_r - $signed(term_sh)) : (acc_r + $signed(term_sh));
    end
  end

endmodule

// ===== hw/rtl/point_in_polygon_test_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_polygon_test_core: even-odd ray casting point-in-polygon tester
// Holds one polygon ring in a vertex RAM and counts edge crossings to the
// right of a query point with an exact cross-multiplied compare.
// ----------------------------------------------------------------------------
// Channel | Dir | tdata (low bit up)              | tuser
// in_     | in  | x_coord, y_coord (COORD_BITS ea) | operation (2b)
// out_    | out | inside_res, crossing_count(8),   | -
//         |     | vertices_dropped, zero pad       |
//
// Start and append words are taken while the core stays idle. A test word
// reads each stored vertex in turn through ST_RD and ST_LOAD (one RAM read
// port); an edge whose y span holds the query also runs the 16-bit digit
// multiplier through ST_MUL and ST_CHK, and ST_FIN then posts the result.
// in_tready is low for the whole test; a result waiting on out_tready holds
// only the next test. Synchronous active-low reset; the vertex RAM is not
// cleared and needs no sweep.
// ----------------------------------------------------------------------------
module point_in_polygon_test_core
  import pip_pkg::*;
#(
  parameter int MAX_VERTICES = 256,
  parameter int COORD_BITS   = 32
) (
  input  logic clk,
  input  logic rst_n,
  // x_coord, y_coord, zero pad
  input  logic [((2*COORD_BITS+7)/8)*8-1:0] in_tdata,
  // operation
  input  logic [OP_BITS-1:0]                in_tuser,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // inside_res, crossing_count[7:0], vertices_dropped, zero pad
  output logic [OUT_DATA_W-1:0]             out_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready
);

  localparam int CB = COORD_BITS;
  localparam int D  = CB + 1;
  localparam int AB = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  pip_state_t state_r, state_nxt;

  logic [CW-1:0]        count_r;
  logic                 ovf_r;
  logic [AB-1:0]        idx_r;
  logic signed [CB-1:0] qx_r, qy_r, px_r, py_r;
  logic [CNT_BITS-1:0]  cross_r;
  logic                 par_r;
  logic                 out_valid_r;
  logic                 ins_r, drop_r;
  logic [CNT_BITS-1:0]  cnt_r;

  logic signed [CB-1:0] in_x, in_y, cur_x, cur_y;
  logic signed [CB-1:0] ax, ay, bx, by;
  logic signed [D-1:0]  d1a, d1b, d2a, d2b;
  logic                 hit, last_vtx, has_room;
  logic                 accept;
  logic                 idx_inc, out_load;

  logic                 ram_we, ram_re;
  logic [AB-1:0]        ram_waddr;
  logic [2*CB-1:0]      ram_rdata;

  pip_mac_ctl_t mac_ctl;
  pip_mac_sts_t mac_sts;

  assign in_x = in_tdata[CB-1:0];
  assign in_y = in_tdata[2*CB-1:CB];
  assign cur_x = ram_rdata[CB-1:0];
  assign cur_y = ram_rdata[2*CB-1:CB];

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign has_room  = count_r < CW'(MAX_VERTICES);
  assign last_vtx  = (CW'(idx_r) + CW'(1)) >= count_r;

  // orient edge so that (ax, ay) is the lower end
  always_comb begin
    if (py_r < cur_y) begin
      ax = px_r;  ay = py_r;  bx = cur_x; by = cur_y;
    end else begin
      ax = cur_x; ay = cur_y; bx = px_r;  by = py_r;
    end
  end

  assign hit = (idx_r != '0) && (py_r != cur_y) && (qy_r >= ay) && (qy_r < by);

  assign d1a = D'(qy_r) - D'(ay);
  assign d1b = D'(bx)   - D'(ax);
  assign d2a = D'(qx_r) - D'(ax);
  assign d2b = D'(by)   - D'(ay);

  always_comb begin
    state_nxt    = state_r;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = '0;
    mac_ctl      = '0;
    idx_inc      = 1'b0;
    out_load     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_tuser)
            OP_START:  ram_we = 1'b1;
            OP_APPEND: begin
              ram_we    = has_room;
              ram_waddr = count_r[AB-1:0];
            end
            OP_TEST:   state_nxt = ST_RD;
            default:   ;
          endcase
        end
      end
      ST_RD: begin
        ram_re    = 1'b1;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (hit) begin
          mac_ctl.load = 1'b1;
          state_nxt    = ST_MUL;
        end else if (last_vtx) begin
          state_nxt = ST_FIN;
        end else begin
          idx_inc   = 1'b1;
          state_nxt = ST_RD;
        end
      end
      ST_MUL: begin
        mac_ctl.step = 1'b1;
        if (mac_sts.last) begin
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        if (last_vtx) begin
          state_nxt = ST_FIN;
        end else begin
          idx_inc   = 1'b1;
          state_nxt = ST_RD;
        end
      end
      ST_FIN: begin
        // hold until the output register is free
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept && in_tuser == OP_START) begin
        count_r <= CW'(1);
        ovf_r   <= 1'b0;
      end else if (accept && in_tuser == OP_APPEND) begin
        if (has_room) begin
          count_r <= count_r + CW'(1);
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_tuser == OP_TEST) begin
      qx_r    <= in_x;
      qy_r    <= in_y;
      idx_r   <= '0;
      cross_r <= '0;
      par_r   <= 1'b0;
    end else begin
      if (idx_inc) begin
        idx_r <= idx_r + AB'(1);
      end
      if (state_r == ST_LOAD) begin
        px_r <= cur_x;
        py_r <= cur_y;
      end
      if (state_r == ST_CHK && mac_sts.pos) begin
        par_r <= ~par_r;
        if (cross_r != CNT_MAX) begin
          cross_r <= cross_r + CNT_BITS'(1);
        end
      end
    end
    if (out_load) begin
      ins_r  <= par_r;
      cnt_r  <= cross_r;
      drop_r <= ovf_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'({drop_r, cnt_r, ins_r});

  pip_ram #(
    .WIDTH (2 * CB),
    .DEPTH (MAX_VERTICES)
  ) u_vtx_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data ({in_y, in_x}),
    .rd_en   (ram_re),
    .rd_addr (idx_r),
    .rd_data (ram_rdata)
  );

  pip_mac #(
    .D (D)
  ) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .a1    (d1a),
    .b1    (d1b),
    .a2    (d2a),
    .b2    (d2b),
    .sts   (mac_sts)
  );

endmodule

// ===== hw/rtl/pip_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_chk: port-level checker for the point-in-polygon test core
// Watches the stream ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module pip_chk
  import pip_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic [OP_BITS-1:0]    in_tuser,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tvalid,
  input logic                  out_tready
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // a test word keeps the core busy the next cycle
  a_test_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == OP_TEST |=> !in_tready)
    else $error("core ready right after accepting a test");

  // vertex and unused words leave the core ready the next cycle
  a_write_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser != OP_TEST |=> in_tready)
    else $error("core busy after a vertex word");

  // below saturation the inside flag is the count parity
  a_parity: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[8:1] != CNT_MAX |-> out_tdata[0] == out_tdata[1])
    else $error("inside flag disagrees with crossing count");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind point_in_polygon_test_core pip_chk u_pip_chk (.*);

// ===== bench/pip_crossing_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_crossing_check: result checker for the point-in-polygon test core
// Tracks the vertex ring from every accepted input word and predicts the
// crossing count, parity and drop flag of each test word. Each result word
// is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module pip_crossing_check
  import pip_pkg::*;
#(
  parameter int MAX_VERTICES = 256,
  parameter int COORD_BITS   = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // x_coord, y_coord, zero pad
  input  logic [((2*COORD_BITS+7)/8)*8-1:0] in_tdata,
  // operation
  input  logic [OP_BITS-1:0]                in_tuser,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  // inside_res, crossing_count[7:0], vertices_dropped, zero pad
  input  logic [OUT_DATA_W-1:0]             out_tdata,
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  output int                                fail_count,
  output int                                pending,
  output int                                checked
);

  localparam int VQ_AW    = 4;
  localparam int VQ_DEPTH = 1 << VQ_AW;
  localparam int DW       = COORD_BITS + 2;
  localparam int PW       = 2 * COORD_BITS + 4;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic [OUT_DATA_W-11:0] pad;
    logic                   dropped;
    logic [CNT_BITS-1:0]    crossings;
    logic                   in_poly;
  } pip_result_t;

  coord_t      ring_x [MAX_VERTICES];
  coord_t      ring_y [MAX_VERTICES];
  int unsigned ring_len;
  logic        ring_dropped;
  pip_result_t verdict_q [VQ_DEPTH];
  logic [VQ_AW-1:0] vq_rd, vq_wr;
  int          vq_count;

  // Walk the stored edges and count those whose x at qy lies right of qx.
  function automatic pip_result_t predict_test(input coord_t qx, input coord_t qy);
    coord_t                         ax, ay, bx, by, t;
    logic signed [COORD_BITS+1:0]   dy_q, dx_e, dx_q, dy_e;
    logic signed [2*COORD_BITS+3:0] lhs, rhs;
    logic                           parity;
    int unsigned                    hits;
    int unsigned                    i;
    pip_result_t                    res;
    parity = 1'b0;
    hits   = 0;
    for (i = 0; i + 1 < ring_len; i++) begin
      ax = ring_x[i];
      ay = ring_y[i];
      bx = ring_x[i+1];
      by = ring_y[i+1];
      if (ay == by) continue;
      if (ay > by) begin
        t = ax; ax = bx; bx = t;
        t = ay; ay = by; by = t;
      end
      // half-open in y: bottom end in, top end out
      if (qy < ay || qy >= by) continue;
      dy_q = DW'(qy) - DW'(ay);
      dx_e = DW'(bx) - DW'(ax);
      dx_q = DW'(qx) - DW'(ax);
      dy_e = DW'(by) - DW'(ay);
      lhs  = PW'(dy_q) * PW'(dx_e);
      rhs  = PW'(dx_q) * PW'(dy_e);
      if (lhs > rhs) begin
        parity = ~parity;
        if (hits < CNT_MAX) hits++;
      end
    end
    res           = '0;
    res.in_poly   = parity;
    res.crossings = CNT_BITS'(hits);
    res.dropped   = ring_dropped;
    return res;
  endfunction

  task automatic report_mismatch(input string field, input int unsigned got,
                                 input int unsigned want);
    $display("[%0t] MISMATCH result %0d %s: got %0d, expected %0d",
             $realtime, checked + 1, field, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    coord_t      qx, qy;
    pip_result_t got, want;
    if (!rst_n) begin
      ring_len     = 0;
      ring_dropped = 1'b0;
      vq_rd        = '0;
      vq_wr        = '0;
      vq_count     = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (vq_count == 0) begin
          report_mismatch("word with no test pending (tdata)", 32'(out_tdata), 0);
        end else begin
          want     = verdict_q[vq_rd];
          vq_rd    = vq_rd + VQ_AW'(1);
          vq_count = vq_count - 1;
          if (got.in_poly !== want.in_poly)
            report_mismatch("inside_res", 32'(got.in_poly), 32'(want.in_poly));
          if (got.crossings !== want.crossings)
            report_mismatch("crossing_count", 32'(got.crossings), 32'(want.crossings));
          if (got.dropped !== want.dropped)
            report_mismatch("vertices_dropped", 32'(got.dropped), 32'(want.dropped));
          if (got.pad !== want.pad)
            report_mismatch("pad bits", 32'(got.pad), 32'(want.pad));
          checked++;
        end
      end
      if (in_tvalid && in_tready) begin
        qx = in_tdata[COORD_BITS-1:0];
        qy = in_tdata[2*COORD_BITS-1:COORD_BITS];
        case (in_tuser)
          OP_START: begin
            ring_x[0]    = qx;
            ring_y[0]    = qy;
            ring_len     = 1;
            ring_dropped = 1'b0;
          end
          OP_APPEND: begin
            if (ring_len < MAX_VERTICES) begin
              ring_x[ring_len] = qx;
              ring_y[ring_len] = qy;
              ring_len++;
            end else begin
              ring_dropped = 1'b1;
            end
          end
          OP_TEST: begin
            if (vq_count == VQ_DEPTH) begin
              report_mismatch("prediction queue overflow", 32'(vq_count), 0);
            end else begin
              verdict_q[vq_wr] = predict_test(qx, qy);
              vq_wr            = vq_wr + VQ_AW'(1);
              vq_count         = vq_count + 1;
            end
          end
          default: ;
        endcase
      end
    end
    pending <= vq_count;
  end

endmodule

// ===== bench/point_in_polygon_test_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_polygon_test_core_tb: stimulus and verdict for the polygon tester
// Builds rings of edge-case, random and full-table vertices, fires query
// points at them with random idling on both streams, and leaves prediction
// and comparison to pip_crossing_check.
// ----------------------------------------------------------------------------
module point_in_polygon_test_core_tb;
  import pip_pkg::*;

  localparam int MAX_VERTICES = 256;
  localparam int COORD_BITS   = 32;
  localparam int IN_W         = ((2*COORD_BITS+7)/8)*8;
  localparam int N_WORDS      = 2000;
  localparam int IDLE_PCT     = 32;
  localparam int CALM_FIRST   = 900;
  localparam int CALM_LAST    = 1200;
  // slowest test: full table, every edge spans qy
  localparam int STALL_LIMIT  = 20000;
  localparam int TAIL_CYCLES  = 3000;

  localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef enum int {SPAN_FULL, SPAN_TINY, SPAN_MID, SPAN_WIDE} span_t;

  localparam coord_t C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam coord_t C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic [IN_W-1:0]       in_tdata;
  logic [OP_BITS-1:0]    in_tuser;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  calm = 1'b0;

  int fail_count, pending, checked;
  int n_words, n_tests, n_rings, stall_cycles;

  always #10 clk = ~clk;

  point_in_polygon_test_core #(
    .MAX_VERTICES(MAX_VERTICES),
    .COORD_BITS  (COORD_BITS)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready)
  );

  pip_crossing_check #(
    .MAX_VERTICES(MAX_VERTICES),
    .COORD_BITS  (COORD_BITS)
  ) crossing_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .fail_count(fail_count),
    .pending   (pending),
    .checked   (checked)
  );

  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("[%0t] watchdog: no word moved for %0d cycles", $realtime, STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic coord_t pick_coord(input span_t span);
    int unsigned r;
    case (span)
      SPAN_FULL: return coord_t'($urandom);
      SPAN_TINY: r = 16;
      SPAN_MID:  r = 1 << 20;
      default:   r = 1 << 30;
    endcase
    return coord_t'($urandom_range(0, 2 * r)) - coord_t'(r);
  endfunction

  // Present one word, idling at random first, and hold it until taken.
  task automatic send_word(input logic [OP_BITS-1:0] op, input coord_t x, input coord_t y);
    bit no_idle;
    no_idle = (n_words >= CALM_FIRST && n_words < CALM_LAST);
    calm <= no_idle;
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= IN_W'({y, x});
    do @(posedge clk); while (!in_tready);
    if (op != OP_UNUSED) n_words++;
    if (op == OP_TEST) n_tests++;
    if (op == OP_START) n_rings++;
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic random_ring(input bit leave_open);
    coord_t px [16];
    coord_t py [16];
    coord_t qx, qy;
    span_t  span;
    int     k, n_q, v;
    span = span_t'($urandom_range(SPAN_FULL, SPAN_WIDE));
    k    = $urandom_range(2, 15);
    for (int i = 0; i < k; i++) begin
      px[i] = pick_coord(span);
      py[i] = pick_coord(span);
    end
    send_word(OP_START, px[0], py[0]);
    for (int i = 1; i < k; i++) send_word(OP_APPEND, px[i], py[i]);
    if (!leave_open) send_word(OP_APPEND, px[0], py[0]);
    n_q = $urandom_range(1, 6);
    for (int j = 0; j < n_q; j++) begin
      v = $urandom_range(0, k - 1);
      case ($urandom_range(0, 3))
        0: begin
          qx = px[v];
          qy = py[v];
        end
        // sit on a vertex's y to exercise the half-open span
        1: begin
          qx = pick_coord(span);
          qy = py[v];
        end
        default: begin
          qx = pick_coord(span);
          qy = pick_coord(span);
        end
      endcase
      if ($urandom_range(0, 15) == 0)
        send_word(OP_UNUSED, coord_t'($urandom), coord_t'($urandom));
      send_word(OP_TEST, qx, qy);
    end
  endtask

  // Fill the table with edges that all span y = 0, then overflow it.
  task automatic zigzag_ring();
    coord_t lo, hi, x0, step;
    int     extra;
    lo   = -coord_t'($urandom_range(1, 1 << 20));
    hi   = coord_t'($urandom_range(1, 1 << 20));
    x0   = pick_coord(SPAN_MID);
    step = coord_t'($urandom_range(1, 4096));
    send_word(OP_START, x0, lo);
    for (int i = 1; i < MAX_VERTICES; i++)
      send_word(OP_APPEND, x0 + step * coord_t'(i), (i % 2) ? hi : lo);
    send_word(OP_TEST, C_MIN, '0);
    extra = $urandom_range(1, 6);
    repeat (extra) send_word(OP_APPEND, pick_coord(SPAN_FULL), pick_coord(SPAN_FULL));
    send_word(OP_TEST, C_MIN, '0);
    send_word(OP_TEST, pick_coord(SPAN_MID), pick_coord(SPAN_TINY));
  endtask

  task automatic noise_burst();
    int n;
    n = $urandom_range(1, 4);
    repeat (n)
      send_word(OP_BITS'($urandom_range(OP_START, OP_UNUSED)),
                coord_t'($urandom), coord_t'($urandom));
  endtask

  initial begin
    int ring_no, roll;
    bit paused;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= OP_START;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // empty table, then a single vertex: no edges
    send_word(OP_TEST, '0, '0);
    send_word(OP_START, 5, 5);
    send_word(OP_TEST, 5, 5);
    send_word(OP_UNUSED, C_MAX, C_MIN);
    // full-scale square, closed, with horizontal top and bottom
    send_word(OP_START, C_MIN, C_MIN);
    send_word(OP_APPEND, C_MAX, C_MIN);
    send_word(OP_APPEND, C_MAX, C_MAX);
    send_word(OP_APPEND, C_MIN, C_MAX);
    send_word(OP_APPEND, C_MIN, C_MIN);
    send_word(OP_TEST, '0, '0);
    send_word(OP_TEST, C_MIN, C_MIN);
    send_word(OP_TEST, C_MAX, C_MAX);
    send_word(OP_TEST, C_MAX, '0);
    send_word(OP_TEST, C_MIN, '0);
    // small triangle: on a slanted edge, just left of it, and at a vertex y
    send_word(OP_START, 0, 0);
    send_word(OP_APPEND, 4, 2);
    send_word(OP_APPEND, 0, 4);
    send_word(OP_APPEND, 0, 0);
    send_word(OP_TEST, 2, 1);
    send_word(OP_TEST, 1, 1);
    send_word(OP_TEST, -1, 2);
    // full-scale diagonal edge stresses the widest products
    send_word(OP_START, C_MIN, C_MIN);
    send_word(OP_APPEND, C_MAX, C_MAX);
    send_word(OP_TEST, '0, -1);
    send_word(OP_TEST, C_MAX, C_MIN);

    ring_no = 0;
    paused  = 1'b0;
    while (n_words < N_WORDS) begin
      if (ring_no == 2) begin
        zigzag_ring();
      end else if (!paused && n_words >= N_WORDS / 2) begin
        drain_results();
        paused = 1'b1;
        zigzag_ring();
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 10) noise_burst();
        else random_ring(roll < 16);
      end
      ring_no++;
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d words: %0d rings, %0d point tests; %0d results compared.",
             n_words, n_rings, n_tests, checked);
    $display("Rings ranged from empty to a full %0d-vertex table with dropped vertices.",
             MAX_VERTICES);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/pip_pkg.sv
hw/rtl/pip_ram.sv
hw/rtl/pip_mac.sv
hw/rtl/point_in_polygon_test_core.sv
hw/rtl/pip_chk.sv
bench/pip_crossing_check.sv
bench/point_in_polygon_test_core_tb.sv
